### src/cwsc_pkg.sv
// Shared types and constants for the CSS white-space collapser.
`timescale 1ns / 1ps
package cwsc_pkg;

  localparam int unsigned CHAR_WIDTH    = 16;
  localparam int unsigned COUNT_WIDTH   = 16;
  localparam int unsigned CFG_IDX_WIDTH = 2;
  localparam int unsigned FIFO_DEPTH    = 4;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_KEEP_LF = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_KEEP_SP = 2'd1;

  localparam logic [CHAR_WIDTH-1:0] CH_LF = 16'h000A;
  localparam logic [CHAR_WIDTH-1:0] CH_CR = 16'h000D;
  localparam logic [CHAR_WIDTH-1:0] CH_SP = 16'h0020;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] ch;
    logic                  last;
    logic                  changed;
  } res_t;

  typedef struct packed {
    logic keep_lf;
    logic keep_sp;
  } cfg_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

### src/cwsc_in_reg.sv
// Input register holding one beat in front of the collapsing logic.
`timescale 1ns / 1ps
module cwsc_in_reg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [cwsc_pkg::CHAR_WIDTH-1:0] char_i,
  input  logic                            last_i,
  input  logic                            take_i,
  output logic                            in_stall_o,
  output logic                            valid_o,
  output logic [cwsc_pkg::CHAR_WIDTH-1:0] char_o,
  output logic                            last_o
);

  logic                            valid_q, valid_d;
  logic [cwsc_pkg::CHAR_WIDTH-1:0] char_q;
  logic                            last_q;
  logic                            load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;

endmodule

### src/cwsc_core.sv
// Collapsing logic and per-string state; yields up to two results per beat.
`timescale 1ns / 1ps
module cwsc_core #(
  parameter int unsigned COUNT_WIDTH = cwsc_pkg::COUNT_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  logic [cwsc_pkg::CHAR_WIDTH-1:0] char_i,
  input  logic                            last_i,
  input  cwsc_pkg::cfg_t                  cfg_i,
  output cwsc_pkg::push_t                 push_o
);

  logic                            run_q, run_d;
  logic                            hb_q, hb_d;
  logic                            conv_q, conv_d;
  logic [COUNT_WIDTH-1:0]          inc_q, inc_d;
  logic [COUNT_WIDTH-1:0]          outc_q, outc_d;
  logic [COUNT_WIDTH-1:0]          inc_next, outc_next;
  logic [cwsc_pkg::CHAR_WIDTH-1:0] ch, e0, e1, pend, tail;
  logic [1:0]                      n;
  logic                            brk, last0, last1, chg;

  always_comb begin
    ch        = char_i;
    e0        = '0;
    e1        = '0;
    n         = 2'd0;
    run_d     = run_q;
    hb_d      = hb_q;
    conv_d    = conv_q;
    brk       = 1'b0;
    last0     = 1'b0;
    last1     = 1'b0;
    chg       = 1'b0;
    pend      = hb_q ? cwsc_pkg::CH_LF : cwsc_pkg::CH_SP;
    inc_next  = inc_q + COUNT_WIDTH'(1);

    if (cfg_i.keep_lf && cfg_i.keep_sp) begin
      if (run_q) begin
        e0 = pend;
        e1 = char_i;
        n  = 2'd2;
      end else begin
        e0 = char_i;
        n  = 2'd1;
      end
      run_d = 1'b0;
      hb_d  = 1'b0;
    end else begin
      if (!cfg_i.keep_lf && (ch == cwsc_pkg::CH_LF || ch == cwsc_pkg::CH_CR)) begin
        ch     = cwsc_pkg::CH_SP;
        conv_d = 1'b1;
      end
      brk = (ch == cwsc_pkg::CH_LF || ch == cwsc_pkg::CH_CR);
      if (run_q) begin
        if (ch != cwsc_pkg::CH_SP) begin
          if (brk) begin
            hb_d = 1'b1;
          end else begin
            e0    = pend;
            e1    = ch;
            n     = 2'd2;
            run_d = 1'b0;
            hb_d  = 1'b0;
          end
        end
      end else if (!cfg_i.keep_sp && ch == cwsc_pkg::CH_SP) begin
        run_d = 1'b1;
      end else if (!cfg_i.keep_sp && brk) begin
        run_d = 1'b1;
        hb_d  = 1'b1;
      end else begin
        e0 = ch;
        n  = 2'd1;
      end
    end

    tail = hb_d ? cwsc_pkg::CH_LF : cwsc_pkg::CH_SP;
    if (last_i && run_d) begin
      // run still open at end of string: flush it
      if (n == 2'd0) begin
        e0 = tail;
      end else begin
        e1 = tail;
      end
      n = n + 2'd1;
    end

    outc_next = outc_q + COUNT_WIDTH'(n);
    inc_d     = inc_next;
    outc_d    = outc_next;

    if (last_i) begin
      chg = (outc_next != inc_next) || conv_d;
      if (n == 2'd1) begin
        last0 = 1'b1;
      end else begin
        last1 = 1'b1;
      end
      run_d  = 1'b0;
      hb_d   = 1'b0;
      conv_d = 1'b0;
      inc_d  = '0;
      outc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      hb_q   <= 1'b0;
      conv_q <= 1'b0;
      inc_q  <= '0;
      outc_q <= '0;
    end else if (fire_i) begin
      run_q  <= run_d;
      hb_q   <= hb_d;
      conv_q <= conv_d;
      inc_q  <= inc_d;
      outc_q <= outc_d;
    end
  end

  assign push_o.n          = fire_i ? n : 2'd0;
  assign push_o.r0.ch      = e0;
  assign push_o.r0.last    = last0;
  assign push_o.r0.changed = last0 && chg;
  assign push_o.r1.ch      = e1;
  assign push_o.r1.last    = last1;
  assign push_o.r1.changed = last1 && chg;

endmodule

### src/cwsc_out_fifo.sv
// Small result queue: takes up to two results per cycle, sends one per beat.
`timescale 1ns / 1ps
module cwsc_out_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cwsc_pkg::push_t                 push_i,
  input  logic                            out_stall_i,
  output logic                            room_o,
  output logic                            out_valid_o,
  output logic [cwsc_pkg::CHAR_WIDTH-1:0] char_o,
  output logic                            last_o,
  output logic                            changed_o
);

  localparam int unsigned PtrW = $clog2(cwsc_pkg::FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(cwsc_pkg::FIFO_DEPTH + 1);

  cwsc_pkg::res_t  mem [cwsc_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= CntW'(cwsc_pkg::FIFO_DEPTH - 2));

  assign wr_d  = wr_q + PtrW'(push_i.n);
  assign rd_d  = rd_q + PtrW'(pop);
  assign cnt_d = cnt_q + CntW'(push_i.n) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem[wr_q + PtrW'(1)] <= push_i.r1;
    end
  end

  assign char_o    = mem[rd_q].ch;
  assign last_o    = mem[rd_q].last;
  assign changed_o = mem[rd_q].changed;

endmodule

### src/css_whitespace_collapser_unit.sv
// Top level of the CSS white-space collapser.
//
//  channel | direction | handshake                   | payload
//  in      | input     | in_valid_i / in_stall_o     | char_in_i, last_in_i
//  out     | output    | out_valid_o / out_stall_i   | char_out_o, last_out_o, string_changed_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// One input beat is taken per cycle while the queue has room; beats pass the input register
// and the result queue. A beat can yield two results; the output port sends one per cycle
// unless stalled, so it alone sets the sustained rate when pending runs are flushed. A
// four-entry result queue decouples the sides; input stalls when it holds more than two
// results and the input register is full. Reset clears all state at once; no clearing pass.
`timescale 1ns / 1ps
module css_whitespace_collapser_unit #(
  parameter int unsigned COUNT_WIDTH = cwsc_pkg::COUNT_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [cwsc_pkg::CHAR_WIDTH-1:0]    char_in_i,
  input  logic                               last_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [cwsc_pkg::CHAR_WIDTH-1:0]    char_out_o,
  output logic                               last_out_o,
  output logic                               string_changed_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cwsc_pkg::CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic                               cfg_data_i
);

  cwsc_pkg::cfg_t                  cfg_q, cfg_d;
  cwsc_pkg::push_t                 push;
  logic                            room, fire, stg_valid, stg_last;
  logic [cwsc_pkg::CHAR_WIDTH-1:0] stg_char;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        cwsc_pkg::CFG_KEEP_LF: cfg_d.keep_lf = cfg_data_i;
        cwsc_pkg::CFG_KEEP_SP: cfg_d.keep_sp = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign fire = stg_valid && room;

  cwsc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .char_i     (char_in_i),
    .last_i     (last_in_i),
    .take_i     (fire),
    .in_stall_o (in_stall_o),
    .valid_o    (stg_valid),
    .char_o     (stg_char),
    .last_o     (stg_last)
  );

  cwsc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .char_i (stg_char),
    .last_i (stg_last),
    .cfg_i  (cfg_q),
    .push_o (push)
  );

  cwsc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_stall_i (out_stall_i),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .char_o      (char_out_o),
    .last_o      (last_out_o),
    .changed_o   (string_changed_o)
  );

endmodule

### tb/tb_css_whitespace_collapser_unit.sv
// Self-checking testbench for the CSS white-space collapser: directed cases plus random streams.
`timescale 1ns / 1ps
module tb_css_whitespace_collapser_unit;
  import cwsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned MAX_REPORTS = 100;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_B = 2'd3;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [CHAR_WIDTH-1:0]    char_in_i;
  logic                     last_in_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [CHAR_WIDTH-1:0]    char_out_o;
  logic                     last_out_o;
  logic                     string_changed_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0] cfg_index_i;
  logic                     cfg_data_i;

  css_whitespace_collapser_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_in_i        (char_in_i),
    .last_in_i        (last_in_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .char_out_o       (char_out_o),
    .last_out_o       (last_out_o),
    .string_changed_o (string_changed_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // collapser state as the block should hold it
  logic                   keep_lf   = 1'b0;
  logic                   keep_sp   = 1'b0;
  logic                   run_open  = 1'b0;
  logic                   run_brk   = 1'b0;
  logic                   brk_conv  = 1'b0;
  logic [COUNT_WIDTH-1:0] in_cnt    = '0;
  logic [COUNT_WIDTH-1:0] out_cnt   = '0;

  res_t        exp_chars_q[$];
  int unsigned errs        = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned beats_in    = 0;
  int unsigned strings_in  = 0;
  int unsigned results_ok  = 0;
  int unsigned reg_writes  = 0;
  int unsigned tx_gap_pct  = 0;
  int unsigned rx_busy_pct = 0;
  int unsigned hold_cnt    = 0;

  assign out_stall_i = (hold_cnt != 0);

  function automatic int unsigned pick_idle();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (rx_busy_pct != 0 && $urandom_range(0, 99) < rx_busy_pct) begin
      hold_cnt <= pick_idle();
    end
  end

  task automatic emit_char(input logic [CHAR_WIDTH-1:0] c);
    exp_chars_q.push_back({c, 1'b0, 1'b0});
    out_cnt++;
  endtask

  task automatic collapse_step(input logic [CHAR_WIDTH-1:0] c, input logic last);
    logic [CHAR_WIDTH-1:0] ch;
    logic                  is_brk;
    res_t                  tail;
    ch = c;
    in_cnt++;
    if (keep_lf && keep_sp) begin
      if (run_open) begin
        emit_char(run_brk ? CH_LF : CH_SP);
        run_open = 1'b0;
        run_brk  = 1'b0;
      end
      emit_char(ch);
    end else begin
      if (!keep_lf && (ch == CH_LF || ch == CH_CR)) begin
        ch       = CH_SP;
        brk_conv = 1'b1;
      end
      is_brk = (ch == CH_LF || ch == CH_CR);
      if (run_open) begin
        if (is_brk) begin
          run_brk = 1'b1;
        end else if (ch != CH_SP) begin
          emit_char(run_brk ? CH_LF : CH_SP);
          run_open = 1'b0;
          run_brk  = 1'b0;
          emit_char(ch);
        end
      end else if (!keep_sp && ch == CH_SP) begin
        run_open = 1'b1;
      end else if (!keep_sp && is_brk) begin
        run_open = 1'b1;
        run_brk  = 1'b1;
      end else begin
        emit_char(ch);
      end
    end
    if (last) begin
      if (run_open) emit_char(run_brk ? CH_LF : CH_SP);
      tail         = exp_chars_q.pop_back();
      tail.last    = 1'b1;
      tail.changed = (out_cnt != in_cnt) || brk_conv;
      exp_chars_q.push_back(tail);
      run_open = 1'b0;
      run_brk  = 1'b0;
      brk_conv = 1'b0;
      in_cnt   = '0;
      out_cnt  = '0;
      strings_in++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    res_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, exp_chars_q.size());
      $display("tb_css_whitespace_collapser_unit NOT OK");
      $finish;
    end else if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (exp_chars_q.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS)
            $display("%0t: unexpected beat char %h last %b changed %b", $time,
                     char_out_o, last_out_o, string_changed_o);
        end else begin
          want = exp_chars_q.pop_front();
          if (char_out_o !== want.ch || last_out_o !== want.last ||
              string_changed_o !== want.changed) begin
            errs++;
            if (errs <= MAX_REPORTS) begin
              if (char_out_o !== want.ch)
                $display("%0t: char_out expected %h actual %h", $time, want.ch, char_out_o);
              if (last_out_o !== want.last)
                $display("%0t: last_out expected %b actual %b", $time, want.last, last_out_o);
              if (string_changed_o !== want.changed)
                $display("%0t: string_changed expected %b actual %b", $time, want.changed,
                         string_changed_o);
            end
          end else begin
            results_ok++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        reg_writes++;
        case (cfg_index_i)
          CFG_KEEP_LF: keep_lf = cfg_data_i;
          CFG_KEEP_SP: keep_sp = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        beats_in++;
        collapse_step(char_in_i, last_in_i);
      end
    end
  end

  task automatic send_char(input logic [CHAR_WIDTH-1:0] c, input logic last);
    int unsigned gap;
    gap = 0;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) gap = pick_idle();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    last_in_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++)
      send_char({8'h00, s[i]}, last && (i == s.len() - 1));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (exp_chars_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic val,
                           input bit hold);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (!hold) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_mode(input logic lf, input logic sp);
    drain();
    write_reg(CFG_KEEP_LF, lf, 1'b1);
    write_reg(CFG_KEEP_SP, sp, 1'b0);
  endtask

  // reset values: CR/LF become spaces and runs collapse
  task automatic test_default_mode();
    send_text("a \r\n b", 1'b1);
    send_char(16'hFFFF, 1'b1);
    send_char(16'h0000, 1'b0);
    send_char(CH_SP, 1'b1);
  endtask

  task automatic test_each_mode();
    set_mode(1'b1, 1'b0);
    send_text("x\r \n", 1'b1);
    set_mode(1'b0, 1'b1);
    send_text("\r\n", 1'b1);
    set_mode(1'b1, 1'b1);
    send_text("\r ", 1'b1);
  endtask

  // pending run flushed by passthrough mode, writes to unused indexes ignored
  task automatic test_mode_switch();
    set_mode(1'b1, 1'b0);
    send_text("p\n", 1'b0);
    set_mode(1'b1, 1'b1);
    send_text("q", 1'b1);
    drain();
    write_reg(CFG_SPARE_A, 1'b0, 1'b1);
    write_reg(CFG_SPARE_B, 1'b0, 1'b0);
    send_char(CH_CR, 1'b1);
  endtask

  function automatic logic [CHAR_WIDTH-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 22) return CH_SP;
    if (r < 32) return CH_LF;
    if (r < 40) return CH_CR;
    if (r < 70) return CHAR_WIDTH'($urandom_range(33, 126));
    if (r < 80) return CHAR_WIDTH'($urandom_range(0, 31));
    return CHAR_WIDTH'($urandom);
  endfunction

  task automatic test_random_streams();
    logic lf;
    logic sp;
    logic last;
    for (int ph = 0; ph < 6; ph++) begin
      lf = (ph < 4) ? ph[0] : 1'($urandom);
      sp = (ph < 4) ? ph[1] : 1'($urandom);
      set_mode(lf, sp);
      if (ph == 5) begin
        write_reg(CFG_SPARE_A, 1'($urandom), 1'b1);
        write_reg(CFG_SPARE_B, 1'($urandom), 1'b0);
      end
      tx_gap_pct  = (ph == 2) ? 0 : $urandom_range(5, 40);
      rx_busy_pct = (ph == 2) ? 0 : $urandom_range(5, 40);
      for (int k = 0; k < 150; k++) begin
        last = ($urandom_range(0, 5) == 0);
        if (k == 149) last = 1'($urandom);
        send_char(pick_char(), last);
      end
    end
    tx_gap_pct  = 0;
    rx_busy_pct = 0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_in_i   = '0;
    last_in_i   = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_KEEP_LF;
    cfg_data_i  = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_gap_pct  = 20;
    rx_busy_pct = 20;
    test_default_mode();
    test_each_mode();
    test_mode_switch();
    test_random_streams();
    drain();

    $display("run covered %0d input beats in %0d strings, %0d register writes,",
             beats_in, strings_in, reg_writes);
    $display("all four mode settings, unused register indexes and %0d matching results",
             results_ok);
    if (errs == 0 && exp_chars_q.size() == 0) begin
      $display("tb_css_whitespace_collapser_unit OK");
    end else begin
      $display("tb_css_whitespace_collapser_unit NOT OK");
    end
    $finish;
  end

endmodule
